// ----- rtl/ksa_pkg.sv -----
// Shared types and constants of the key setpoint adjuster.
// Used by ksa_cfg, ksa_key and key_setpoint_adjuster; no dependencies.
package ksa_pkg;

  localparam int unsigned TickW  = 8;
  localparam int unsigned SpW    = 10;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 16;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    REG_SHORT_TICKS  = 3'd0,
    REG_LONG_TICKS   = 3'd1,
    REG_SMALL_STEP   = 3'd2,
    REG_LARGE_STEP   = 3'd3,
    REG_SETPOINT_MIN = 3'd4,
    REG_SETPOINT_MAX = 3'd5
  } reg_idx_e;

  // Values after reset.
  localparam logic [TickW-1:0] ShortTicksRst  = 8'd11;
  localparam logic [TickW-1:0] LongTicksRst   = 8'd200;
  localparam logic [SpW-1:0]   SmallStepRst   = 10'd1;
  localparam logic [SpW-1:0]   LargeStepRst   = 10'd10;
  localparam logic [SpW-1:0]   SetpointMinRst = 10'd100;
  localparam logic [SpW-1:0]   SetpointMaxRst = 10'd600;
  localparam logic [SpW-1:0]   SetpointRst    = 10'd300;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [TickW-1:0] short_ticks;
    logic [TickW-1:0] long_ticks;
    logic [SpW-1:0]   small_step;
    logic [SpW-1:0]   large_step;
    logic [SpW-1:0]   setpoint_min;
    logic [SpW-1:0]   setpoint_max;
  } cfg_t;

  // What one key handler reports for the current tick.
  typedef struct packed {
    logic           event_hit;
    logic [SpW-1:0] delta;
  } key_res_t;

endpackage

// ----- rtl/key_setpoint_adjuster.sv -----
// Top level of the key setpoint adjuster: stream ports, setpoint update
// and result register. Depends on ksa_pkg, ksa_cfg and ksa_key.
//
// Usage: one beat on the slave side is one tick of the key poll, carrying
// the up and down key levels. For each tick exactly one beat comes out on
// the master side with the new setpoint (in tenths) and the two key event
// flags. The up key is handled before the down key; an up event clamps the
// setpoint to setpoint_max from above, a down event to setpoint_min from
// below.
// The output beat comes in the cycle after its input beat. A tick can be
// taken in every cycle unless the receiver stalls: the key state and the
// setpoint update on acceptance and the result sits in a single output register.
// When the receiver stalls, the output register holds its beat and
// s_axis_tready drops until the beat is taken; nothing is lost.
// Reset clears both key counters and fast flags, loads the setpoint with
// 30.0 degrees and the configuration registers with their defaults.
// The user writes configuration through cfg_we_i/cfg_idx_i/cfg_wdata_i,
// one register per cycle, only while no tick is in flight; not enforced.
module key_setpoint_adjuster (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [0] up_pressed, [1] down_pressed, [7:2] zero
  input  logic [ksa_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [9:0] setpoint, [10] up_event, [11] down_event, [15:12] zero
  output logic [ksa_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [ksa_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ksa_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  ksa_pkg::cfg_t     cfg;
  ksa_pkg::key_res_t up_res, dn_res;
  logic              accept;
  logic [ksa_pkg::SpW-1:0] sp_q, sp_d, sp_up;
  logic [ksa_pkg::SpW:0]   up_sum;
  logic [ksa_pkg::SpW+1:0] dn_diff;
  logic                    out_valid_q;
  logic [ksa_pkg::SpW-1:0] out_sp_q;
  logic                    out_up_q, out_dn_q;

  // Take a tick whenever the output register is free or being emptied.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  ksa_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ksa_key u_key_up (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (accept),
    .pressed_i (s_axis_tdata[0]),
    .cfg_i     (cfg),
    .res_o     (up_res)
  );

  ksa_key u_key_dn (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (accept),
    .pressed_i (s_axis_tdata[1]),
    .cfg_i     (cfg),
    .res_o     (dn_res)
  );

  // Up step first, clamped to the upper limit, then the down step,
  // clamped to the lower limit (also when it would go below zero).
  always_comb begin
    up_sum = {1'b0, sp_q} + {1'b0, up_res.delta};
    sp_up  = sp_q;
    if (up_res.event_hit) begin
      if (up_sum >= {1'b0, cfg.setpoint_max}) begin
        sp_up = cfg.setpoint_max;
      end else begin
        sp_up = up_sum[ksa_pkg::SpW-1:0];
      end
    end
    dn_diff = {2'b00, sp_up} - {2'b00, dn_res.delta};
    sp_d    = sp_up;
    if (dn_res.event_hit) begin
      if (dn_diff[ksa_pkg::SpW+1] || (dn_diff <= {2'b00, cfg.setpoint_min})) begin
        sp_d = cfg.setpoint_min;
      end else begin
        sp_d = dn_diff[ksa_pkg::SpW-1:0];
      end
    end
  end

  // Setpoint state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= ksa_pkg::SetpointRst;
    end else if (accept) begin
      sp_q <= sp_d;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_sp_q <= sp_d;
      out_up_q <= up_res.event_hit;
      out_dn_q <= dn_res.event_hit;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_dn_q, out_up_q, out_sp_q};

  // A down event never leaves the setpoint below the lower limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && dn_res.event_hit |-> sp_d >= cfg.setpoint_min)
    else $error("down clamp violated");

  // An up event alone never leaves the setpoint above the upper limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && up_res.event_hit && !dn_res.event_hit |-> sp_d <= cfg.setpoint_max)
    else $error("up clamp violated");

  // The delivered setpoint is the setpoint state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid && (out_sp_q == sp_q))
    else $error("result register out of step with setpoint");

  // Without any event the setpoint stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !up_res.event_hit && !dn_res.event_hit |=> $stable(sp_q))
    else $error("setpoint moved without an event");

endmodule

// ----- rtl/ksa_cfg.sv -----
// Configuration register file of the key setpoint adjuster.
// Depends on ksa_pkg for the register indexes and the cfg_t struct.
module ksa_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ksa_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ksa_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output ksa_pkg::cfg_t                 cfg_o
);

  ksa_pkg::cfg_t cfg_q;

  // One register per index; writes to unused indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_ticks  <= ksa_pkg::ShortTicksRst;
      cfg_q.long_ticks   <= ksa_pkg::LongTicksRst;
      cfg_q.small_step   <= ksa_pkg::SmallStepRst;
      cfg_q.large_step   <= ksa_pkg::LargeStepRst;
      cfg_q.setpoint_min <= ksa_pkg::SetpointMinRst;
      cfg_q.setpoint_max <= ksa_pkg::SetpointMaxRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ksa_pkg::REG_SHORT_TICKS:  cfg_q.short_ticks  <= cfg_wdata_i[ksa_pkg::TickW-1:0];
        ksa_pkg::REG_LONG_TICKS:   cfg_q.long_ticks   <= cfg_wdata_i[ksa_pkg::TickW-1:0];
        ksa_pkg::REG_SMALL_STEP:   cfg_q.small_step   <= cfg_wdata_i[ksa_pkg::SpW-1:0];
        ksa_pkg::REG_LARGE_STEP:   cfg_q.large_step   <= cfg_wdata_i[ksa_pkg::SpW-1:0];
        ksa_pkg::REG_SETPOINT_MIN: cfg_q.setpoint_min <= cfg_wdata_i[ksa_pkg::SpW-1:0];
        ksa_pkg::REG_SETPOINT_MAX: cfg_q.setpoint_max <= cfg_wdata_i[ksa_pkg::SpW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/ksa_key.sv -----
// Hold counter and fast-mode flag of one key, with its step decision.
// Depends on ksa_pkg for cfg_t and key_res_t.
module ksa_key (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                pressed_i,
  input  ksa_pkg::cfg_t       cfg_i,
  output ksa_pkg::key_res_t   res_o
);

  logic [ksa_pkg::TickW-1:0] ticks_q, ticks_d, ticks_inc;
  logic                      fast_q, fast_d;

  assign ticks_inc = ticks_q + 8'd1;

  // Decide the step and the next count for this tick.
  always_comb begin
    ticks_d         = ticks_q;
    fast_d          = fast_q;
    res_o.event_hit = 1'b0;
    res_o.delta     = '0;
    if (pressed_i) begin
      res_o.event_hit = 1'b1;
      ticks_d         = ticks_inc;
      if (ticks_inc == cfg_i.long_ticks) begin
        fast_d      = 1'b1;
        res_o.delta = cfg_i.large_step;
        ticks_d     = '0;
      end
    end else if (!fast_q && (ticks_q >= cfg_i.short_ticks)) begin
      res_o.event_hit = 1'b1;
      res_o.delta     = cfg_i.small_step;
      ticks_d         = '0;
    end else if (fast_q) begin
      res_o.event_hit = 1'b1;
      ticks_d         = '0;
      fast_d          = 1'b0;
    end
  end

  // State advances only when a tick is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= '0;
      fast_q  <= 1'b0;
    end else if (en_i) begin
      ticks_q <= ticks_d;
      fast_q  <= fast_d;
    end
  end

  // A release always leaves fast mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && !pressed_i && fast_q |=> !fast_q && (ticks_q == '0))
    else $error("fast mode not left on release");

  // A short release keeps the count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && !pressed_i && !fast_q && (ticks_q < cfg_i.short_ticks)
    |=> $stable(ticks_q) && !fast_q)
    else $error("short release changed the count");

  // Entering fast mode restarts the count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && !fast_q && fast_d |=> fast_q && (ticks_q == '0))
    else $error("count not cleared on large step");

endmodule
